[src/ffr_pkg.sv]
// Shared types and constants of the firmware fragment receiver.
`default_nettype none
package ffr_pkg;

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_LOSS         = 4'd1,
        ST_SUCCESS      = 4'd2,
        ST_FAILED       = 4'd3,
        ST_TOO_LOSS     = 4'd4,
        ST_NO_START     = 4'd5,
        ST_OVERSIZE     = 4'd6,
        ST_BAD_ID       = 4'd7,
        ST_SAME_VERSION = 4'd8,
        ST_COUNT_ERROR  = 4'd9
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GAP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FILL,
        S_END_CHECK,
        S_LIST_HDR,
        S_LIST_RD,
        S_LIST_OUT,
        S_EMIT
    } t_state;

    localparam logic [2:0] CFG_START_CODE      = 3'd0;
    localparam logic [2:0] CFG_DATA_CODE       = 3'd1;
    localparam logic [2:0] CFG_END_CODE        = 3'd2;
    localparam logic [2:0] CFG_IMAGE_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_DEFAULT_RETRIES = 3'd4;

    localparam logic [7:0] START_MIN_SIZE = 8'd21;
    localparam logic [7:0] OPT_MIN_SIZE   = 8'd22;
    localparam logic [7:0] HDR_BYTES      = 8'd3;
    localparam logic [7:0] END_MARK       = 8'h01;
    localparam logic [7:0] ROUNDS_MAX     = 8'hFF;

endpackage
`default_nettype wire

[src/firmware_fragment_receiver.sv]
// Session controller of an over-the-air firmware download with a loss list memory.
`default_nettype none
// One request is one decoded downlink frame summary; the block answers each with one
// result, or with a loss header followed by one result per listed missing fragment.
// Items are handled one at a time: a start, an ignored frame or a data frame without
// gap goes straight from decode to its result; a gap in the normal numbering writes
// each skipped number to the loss list memory in turn; deleting a reissued number
// searches the list entry by entry and shifts later entries down, since every entry
// goes through the registered read port; the first end frame fills trailing losses
// one number at a time, and a loss report reads the list one entry at a time. Results
// leave through an output register, and a new request is taken once the previous one
// is finished, even while its last result still waits downstream.
// Configuration writes are always ready and take effect at once; write them only
// while idle.
module firmware_fragment_receiver #(
    parameter int LOSS_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_tag,
    input  wire  [7:0]  i_second_byte,
    input  wire  [7:0]  i_frame_low,
    input  wire  [7:0]  i_frame_size,
    input  wire  [23:0] i_image_size,
    input  wire  [15:0] i_total_fragments,
    input  wire  [7:0]  i_fragment_length,
    input  wire  [7:0]  i_option_byte,
    input  wire         i_identity_match,
    input  wire         i_boot_version_new,
    input  wire         i_app_version_new,
    input  wire         i_store_ok,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [3:0]  o_status,
    output logic        o_report,
    output logic        o_write_enable,
    output logic [23:0] o_write_offset,
    output logic        o_boot_target,
    output logic        o_session_active,
    output logic [15:0] o_lost_number,
    output logic        o_last,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    import ffr_pkg::*;

    localparam int CW = $clog2(LOSS_DEPTH + 1);
    localparam int AW = (LOSS_DEPTH > 1) ? $clog2(LOSS_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LOSS_DEPTH);

    // configuration
    logic [7:0]  r_start_code, r_data_code, r_end_code;
    logic [23:0] r_image_limit;
    logic [6:0]  r_default_retries;

    // captured request
    logic [7:0]  r_tag, r_sb, r_lo, r_fsz, r_flen, r_opt;
    logic [23:0] r_isz;
    logic [15:0] r_tot;
    logic        r_idm, r_bvn, r_avn, r_sok;

    // session state
    t_state      r_state, n_state;
    t_status     r_phase, n_phase;
    logic        r_active, n_active;
    logic [15:0] r_total, n_total;
    logic [7:0]  r_frame_len, n_frame_len;
    logic [6:0]  r_retry, n_retry;
    logic        r_boot, n_boot;
    logic [7:0]  r_end_rounds, n_end_rounds;
    logic [15:0] r_stored, n_stored;
    logic [15:0] r_last_normal, n_last_normal;
    logic [CW-1:0] r_loss_count, n_loss_count;
    logic [CW-1:0] r_idx, n_idx;
    logic        r_report, n_report;
    logic        r_we, n_we;
    logic [23:0] r_off, n_off;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_o_status;
    logic        r_o_report, r_o_we, r_o_boot, r_o_active, r_o_last;
    logic [23:0] r_o_off;
    logic [15:0] r_o_lost;

    // loss list memory
    logic [15:0] loss_mem [LOSS_DEPTH];
    logic [15:0] r_rd_data;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata;

    logic        push, push_report, push_last;
    logic [15:0] push_lost;

    logic        in_acc, out_free, loss_full;
    logic [14:0] cur_num;
    logic [16:0] ln_plus1;
    logic        num_gap, num_ok, data_hit, start_hit, end_hit, opening;
    logic [7:0]  dlen, er_next;
    logic [CW:0] idx_p1, idx_p2;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign cur_num   = {r_sb[6:0], r_lo};
    assign ln_plus1  = {1'b0, r_last_normal} + 17'd1;
    assign num_gap   = {2'b00, cur_num} > ln_plus1;
    assign num_ok    = (cur_num != 15'd0) && ({1'b0, cur_num} <= r_total);
    assign loss_full = (r_loss_count >= DEPTH_C);
    assign start_hit = (r_tag == r_start_code) && (r_fsz >= START_MIN_SIZE);
    assign data_hit  = (r_tag == r_data_code) && (r_fsz == r_frame_len);
    assign end_hit   = (r_tag == r_end_code) && (r_sb == END_MARK) && (r_fsz >= HDR_BYTES);
    assign opening   = (r_fsz >= OPT_MIN_SIZE) ? (r_opt[7] ? r_bvn : r_avn) : r_avn;
    assign dlen      = (r_frame_len >= HDR_BYTES) ? (r_frame_len - HDR_BYTES) : 8'd0;
    assign er_next   = (r_end_rounds == ROUNDS_MAX) ? ROUNDS_MAX : (r_end_rounds + 8'd1);
    assign idx_p1    = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_p2    = {1'b0, r_idx} + (CW+1)'(2);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code      <= 8'd1;
            r_data_code       <= 8'd2;
            r_end_code        <= 8'd3;
            r_image_limit     <= 24'd65536;
            r_default_retries <= 7'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_CODE:      r_start_code      <= i_cfg_data[7:0];
                CFG_DATA_CODE:       r_data_code       <= i_cfg_data[7:0];
                CFG_END_CODE:        r_end_code        <= i_cfg_data[7:0];
                CFG_IMAGE_LIMIT:     r_image_limit     <= i_cfg_data;
                CFG_DEFAULT_RETRIES: r_default_retries <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag  <= i_tag;
            r_sb   <= i_second_byte;
            r_lo   <= i_frame_low;
            r_fsz  <= i_frame_size;
            r_isz  <= i_image_size;
            r_tot  <= i_total_fragments;
            r_flen <= i_fragment_length;
            r_opt  <= i_option_byte;
            r_idm  <= i_identity_match;
            r_bvn  <= i_boot_version_new;
            r_avn  <= i_app_version_new;
            r_sok  <= i_store_ok;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_DECODE;
            S_DECODE: begin
                if (r_active && data_hit && num_ok && r_sok) begin
                    if (!r_sb[7]) begin
                        n_state = num_gap ? S_GAP : S_EMIT;
                    end else begin
                        n_state = (r_loss_count == '0) ? S_EMIT : S_SRCH_RD;
                    end
                end else if (r_active && !data_hit && end_hit) begin
                    n_state = (er_next == 8'd1) ? S_FILL : S_END_CHECK;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_GAP: if (!num_gap || loss_full) n_state = S_EMIT;
            S_SRCH_RD: n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (r_rd_data == {1'b0, cur_num}) begin
                    n_state = (idx_p1 < {1'b0, r_loss_count}) ? S_SHIFT_RD : S_EMIT;
                end else begin
                    n_state = (idx_p1 < {1'b0, r_loss_count}) ? S_SRCH_RD : S_EMIT;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = (idx_p2 < {1'b0, r_loss_count}) ? S_SHIFT_RD : S_EMIT;
            S_FILL: begin
                if (r_last_normal != r_total) begin
                    if (loss_full) n_state = S_EMIT;
                end else if (({1'b0, r_stored} + 17'(r_loss_count)) != {1'b0, r_total}) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_END_CHECK;
                end
            end
            S_END_CHECK: begin
                if (r_stored == r_total) n_state = S_EMIT;
                else if ({1'b0, r_end_rounds} >= ({2'b00, r_retry} + 9'd1)) n_state = S_EMIT;
                else n_state = S_LIST_HDR;
            end
            S_LIST_HDR: if (out_free) n_state = (r_loss_count == '0) ? S_IDLE : S_LIST_RD;
            S_LIST_RD: n_state = S_LIST_OUT;
            S_LIST_OUT: if (out_free) n_state = (idx_p1 == {1'b0, r_loss_count}) ? S_IDLE
                                                                                  : S_LIST_RD;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory and result control
    always_comb begin
        n_phase = r_phase;  n_active = r_active;  n_total = r_total;
        n_frame_len = r_frame_len;  n_retry = r_retry;  n_boot = r_boot;
        n_end_rounds = r_end_rounds;  n_stored = r_stored;
        n_last_normal = r_last_normal;  n_loss_count = r_loss_count;
        n_idx = r_idx;  n_report = r_report;
        n_we = r_we;  n_off = r_off;
        mem_we = 1'b0;  mem_re = 1'b0;
        mem_waddr = r_loss_count[AW-1:0];
        mem_wdata = ln_plus1[15:0];
        mem_raddr = r_idx[AW-1:0];
        push = 1'b0;  push_report = r_report;  push_last = 1'b1;  push_lost = 16'd0;
        unique case (r_state)
            S_DECODE: begin
                n_report = 1'b0;  n_we = 1'b0;  n_off = 24'd0;  n_idx = '0;
                if (!r_active) begin
                    if (start_hit) begin
                        n_report = 1'b1;
                        if (r_isz >= r_image_limit) begin
                            n_phase = ST_OVERSIZE;
                        end else if (!r_idm) begin
                            n_phase = ST_BAD_ID;
                        end else begin
                            n_boot  = (r_fsz >= OPT_MIN_SIZE) ? r_opt[7] : 1'b0;
                            n_retry = (r_fsz >= OPT_MIN_SIZE) ? r_opt[6:0] : r_default_retries;
                            if (opening) begin
                                n_report = 1'b0;  n_active = 1'b1;  n_phase = ST_IDLE;
                                n_total = r_tot;  n_frame_len = r_flen;
                                n_end_rounds = 8'd0;  n_stored = 16'd0;
                                n_loss_count = '0;  n_last_normal = 16'd0;
                            end else begin
                                n_phase = ST_SAME_VERSION;
                            end
                        end
                    end else if (r_phase == ST_IDLE && r_tag == r_data_code) begin
                        n_phase = ST_NO_START;  n_report = 1'b1;
                    end
                end else if (data_hit) begin
                    if (num_ok) begin
                        n_we  = 1'b1;
                        n_off = 24'((cur_num - 15'd1) * dlen);
                        if (r_sok) begin
                            n_stored = r_stored + 16'd1;
                            if (!r_sb[7] && !num_gap) n_last_normal = {1'b0, cur_num};
                        end
                    end
                end else if (end_hit) begin
                    n_report = 1'b1;
                    n_end_rounds = er_next;
                end
            end
            S_GAP: begin
                if (num_gap) begin
                    n_last_normal = ln_plus1[15:0];
                    if (loss_full) begin
                        n_active = 1'b0;  n_phase = ST_TOO_LOSS;  n_report = 1'b1;
                        n_last_normal = {1'b0, cur_num};
                    end else begin
                        mem_we = 1'b1;
                        n_loss_count = r_loss_count + CW'(1);
                    end
                end else begin
                    n_last_normal = {1'b0, cur_num};
                end
            end
            S_SRCH_RD: mem_re = 1'b1;
            S_SRCH_CMP: begin
                if (r_rd_data == {1'b0, cur_num}) begin
                    if (!(idx_p1 < {1'b0, r_loss_count})) n_loss_count = r_loss_count - CW'(1);
                end else if (idx_p1 < {1'b0, r_loss_count}) begin
                    n_idx = idx_p1[CW-1:0];
                end
            end
            S_SHIFT_RD: begin
                mem_re = 1'b1;
                mem_raddr = idx_p1[AW-1:0];
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rd_data;
                n_idx = idx_p1[CW-1:0];
                if (!(idx_p2 < {1'b0, r_loss_count})) n_loss_count = r_loss_count - CW'(1);
            end
            S_FILL: begin
                if (r_last_normal != r_total) begin
                    n_last_normal = ln_plus1[15:0];
                    if (loss_full) begin
                        n_active = 1'b0;  n_phase = ST_TOO_LOSS;
                    end else begin
                        mem_we = 1'b1;
                        n_loss_count = r_loss_count + CW'(1);
                    end
                end else if (({1'b0, r_stored} + 17'(r_loss_count)) != {1'b0, r_total}) begin
                    n_active = 1'b0;  n_phase = ST_COUNT_ERROR;
                end
            end
            S_END_CHECK: begin
                if (r_stored == r_total) begin
                    n_active = 1'b0;  n_phase = ST_SUCCESS;
                end else if ({1'b0, r_end_rounds} >= ({2'b00, r_retry} + 9'd1)) begin
                    n_active = 1'b0;  n_phase = ST_FAILED;
                end else begin
                    n_phase = ST_LOSS;
                end
                n_idx = '0;
            end
            S_LIST_HDR: begin
                push = out_free;  push_report = 1'b1;
                push_last = (r_loss_count == '0);
            end
            S_LIST_RD: mem_re = 1'b1;
            S_LIST_OUT: begin
                push = out_free;  push_report = 1'b1;
                push_lost = r_rd_data;
                push_last = (idx_p1 == {1'b0, r_loss_count});
                if (out_free) n_idx = idx_p1[CW-1:0];
            end
            S_EMIT: push = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_phase <= ST_IDLE;  r_active <= 1'b0;
            r_total <= '0;  r_frame_len <= '0;  r_retry <= '0;  r_boot <= 1'b0;
            r_end_rounds <= '0;  r_stored <= '0;  r_last_normal <= '0;
            r_loss_count <= '0;  r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;  r_phase <= n_phase;  r_active <= n_active;
            r_total <= n_total;  r_frame_len <= n_frame_len;  r_retry <= n_retry;
            r_boot <= n_boot;  r_end_rounds <= n_end_rounds;  r_stored <= n_stored;
            r_last_normal <= n_last_normal;  r_loss_count <= n_loss_count;
            r_idx <= n_idx;
            if (push) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // per-request payload and result register
    always_ff @(posedge i_clk) begin
        r_report <= n_report;  r_we <= n_we;  r_off <= n_off;
        if (push) begin
            r_o_status <= r_phase;
            r_o_report <= push_report;
            r_o_we     <= (r_state == S_EMIT) ? r_we : 1'b0;
            r_o_off    <= (r_state == S_EMIT) ? r_off : 24'd0;
            r_o_boot   <= r_boot;
            r_o_active <= r_active;
            r_o_lost   <= push_lost;
            r_o_last   <= push_last;
        end
    end

    // loss list memory
    always_ff @(posedge i_clk) begin
        if (mem_we) loss_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= loss_mem[mem_raddr];
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_report         = r_o_report;
    assign o_write_enable   = r_o_we;
    assign o_write_offset   = r_o_off;
    assign o_boot_target    = r_o_boot;
    assign o_session_active = r_o_active;
    assign o_lost_number    = r_o_lost;
    assign o_last           = r_o_last;

    a_loss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loss_count <= DEPTH_C)
        else $error("loss count beyond list depth");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_list_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == ST_LOSS && o_session_active))
        else $error("multi-result output outside a loss report");

endmodule
`default_nettype wire

[dv/ffr_session_checker.sv]
// Session predictor and result comparator for the firmware fragment receiver bench.
`default_nettype none
module ffr_session_checker #(
    parameter int LOSS_DEPTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire  [7:0]  tag,
    input  wire  [7:0]  second_byte,
    input  wire  [7:0]  frame_low,
    input  wire  [7:0]  frame_size,
    input  wire  [23:0] image_size,
    input  wire  [15:0] total_fragments,
    input  wire  [7:0]  fragment_length,
    input  wire  [7:0]  option_byte,
    input  wire         identity_match,
    input  wire         boot_version_new,
    input  wire         app_version_new,
    input  wire         store_ok,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire  [3:0]  status,
    input  wire         report,
    input  wire         write_enable,
    input  wire  [23:0] write_offset,
    input  wire         boot_target,
    input  wire         session_active,
    input  wire  [15:0] lost_number,
    input  wire         last,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [23:0] cfg_data,
    output int          fail_count,
    output int          open_count
);
    import ffr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  status;
        logic        report;
        logic        we;
        logic [23:0] offset;
        logic        boot;
        logic        active;
        logic [15:0] lost;
        logic        last;
    } t_session_report;

    t_session_report pending_reports[$];

    // copy of the configuration registers
    logic [7:0]  start_code, data_code, end_code;
    logic [23:0] image_limit;
    logic [6:0]  default_retries;

    // copy of the session state
    logic        sess_on;
    t_status     cur_status;
    logic [15:0] frag_total;
    logic [7:0]  frm_len;
    logic [6:0]  retry_limit;
    logic        boot_flag;
    logic [7:0]  end_rounds;
    logic [15:0] stored_cnt;
    logic [15:0] last_normal;
    int          miss_cnt;
    logic [15:0] miss_list [LOSS_DEPTH];

    int fails;

    assign fail_count = fails;

    task automatic queue_report(input logic rep, input logic we, input logic [23:0] off,
                                input logic [15:0] lost, input logic lst);
        t_session_report r;
        r.status = cur_status;
        r.report = rep;
        r.we     = we;
        r.offset = off;
        r.boot   = boot_flag;
        r.active = sess_on;
        r.lost   = lost;
        r.last   = lst;
        pending_reports.push_back(r);
    endtask

    // Record the next skipped number; return 1 when the list is full.
    function automatic bit note_missing();
        last_normal = last_normal + 16'd1;
        if (miss_cnt >= LOSS_DEPTH) return 1'b1;
        miss_list[miss_cnt] = last_normal;
        miss_cnt++;
        return 1'b0;
    endfunction

    task automatic close_session(input t_status st);
        sess_on    = 1'b0;
        cur_status = st;
    endtask

    task automatic predict_frame();
        logic        rep;
        logic        we;
        logic [23:0] off;
        int          num, dlen, n;
        bit          found;
        rep   = 1'b0;
        we    = 1'b0;
        off   = '0;
        found = 1'b0;
        if (!sess_on) begin
            if (tag == start_code && frame_size >= START_MIN_SIZE) begin
                rep = 1'b1;
                if (image_size >= image_limit) begin
                    cur_status = ST_OVERSIZE;
                end else if (!identity_match) begin
                    cur_status = ST_BAD_ID;
                end else begin
                    if (frame_size >= OPT_MIN_SIZE) begin
                        boot_flag   = option_byte[7];
                        retry_limit = option_byte[6:0];
                    end else begin
                        boot_flag   = 1'b0;
                        retry_limit = default_retries;
                    end
                    if (boot_flag ? boot_version_new : app_version_new) begin
                        rep         = 1'b0;
                        sess_on     = 1'b1;
                        cur_status  = ST_IDLE;
                        frag_total  = total_fragments;
                        frm_len     = fragment_length;
                        end_rounds  = '0;
                        stored_cnt  = '0;
                        miss_cnt    = 0;
                        last_normal = '0;
                    end else begin
                        cur_status = ST_SAME_VERSION;
                    end
                end
            end else if (cur_status == ST_IDLE && tag == data_code) begin
                cur_status = ST_NO_START;
                rep        = 1'b1;
            end
        end else if (tag == data_code && frame_size == frm_len) begin
            num = {second_byte[6:0], frame_low};
            if (num != 0 && num <= int'(frag_total)) begin
                dlen = (frm_len >= HDR_BYTES) ? int'(frm_len) - 3 : 0;
                we   = 1'b1;
                off  = 24'((num - 1) * dlen);
                if (store_ok) begin
                    stored_cnt = stored_cnt + 16'd1;
                    if (!second_byte[7]) begin
                        while (num > int'(last_normal) + 1) begin
                            if (note_missing()) begin
                                close_session(ST_TOO_LOSS);
                                rep = 1'b1;
                                break;
                            end
                        end
                        last_normal = 16'(num);
                    end else begin
                        // drop the reissued number from the list and close the gap
                        for (int i = 0; i < miss_cnt && !found; i++) begin
                            if (miss_list[i] == 16'(num)) begin
                                for (int j = i; j + 1 < miss_cnt; j++)
                                    miss_list[j] = miss_list[j + 1];
                                miss_cnt--;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
        end else if (tag == end_code && second_byte == END_MARK && frame_size >= HDR_BYTES) begin
            rep = 1'b1;
            if (end_rounds != ROUNDS_MAX) end_rounds = end_rounds + 8'd1;
            if (end_rounds == 8'd1) begin
                while (last_normal != frag_total) begin
                    if (note_missing()) begin
                        close_session(ST_TOO_LOSS);
                        queue_report(1'b1, 1'b0, '0, '0, 1'b1);
                        return;
                    end
                end
                if (int'(stored_cnt) + miss_cnt != int'(frag_total)) begin
                    close_session(ST_COUNT_ERROR);
                    queue_report(1'b1, 1'b0, '0, '0, 1'b1);
                    return;
                end
            end
            if (stored_cnt == frag_total) begin
                close_session(ST_SUCCESS);
            end else if (int'(end_rounds) >= int'(retry_limit) + 1) begin
                close_session(ST_FAILED);
            end else begin
                n = miss_cnt;
                cur_status = ST_LOSS;
                queue_report(1'b1, 1'b0, '0, '0, n == 0);
                for (int i = 0; i < n; i++)
                    queue_report(1'b1, 1'b0, '0, miss_list[i], i + 1 == n);
                return;
            end
        end
        queue_report(rep, we, off, '0, 1'b1);
    endtask

    task automatic compare_field(input string name, input logic [23:0] exp_v,
                                 input logic [23:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            fails++;
        end
    endtask

    always @(posedge clk) begin
        t_session_report e;
        if (!rst_n) begin
            start_code      = 8'd1;
            data_code       = 8'd2;
            end_code        = 8'd3;
            image_limit     = 24'd65536;
            default_retries = 7'd3;
            sess_on         = 1'b0;
            cur_status      = ST_IDLE;
            frag_total      = '0;
            frm_len         = '0;
            retry_limit     = '0;
            boot_flag       = 1'b0;
            end_rounds      = '0;
            stored_cnt      = '0;
            last_normal     = '0;
            miss_cnt        = 0;
            fails           = 0;
            pending_reports.delete();
            open_count      = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_CODE:      start_code      = cfg_data[7:0];
                    CFG_DATA_CODE:       data_code       = cfg_data[7:0];
                    CFG_END_CODE:        end_code        = cfg_data[7:0];
                    CFG_IMAGE_LIMIT:     image_limit     = cfg_data;
                    CFG_DEFAULT_RETRIES: default_retries = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) predict_frame();
            if (out_valid && !out_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("result with no request outstanding: status %0d", status);
                    fails++;
                end else begin
                    e = pending_reports.pop_front();
                    compare_field("status", e.status, status);
                    compare_field("report", e.report, report);
                    compare_field("write_enable", e.we, write_enable);
                    compare_field("write_offset", e.offset, write_offset);
                    compare_field("boot_target", e.boot, boot_target);
                    compare_field("session_active", e.active, session_active);
                    compare_field("lost_number", e.lost, lost_number);
                    compare_field("last", e.last, last);
                end
            end
            open_count = pending_reports.size();
        end
    end
endmodule
`default_nettype wire

[dv/firmware_fragment_receiver_test.sv]
// Top of the firmware fragment receiver bench: stimulus, idling and verdict.
`default_nettype none
module firmware_fragment_receiver_test;
    import ffr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct {
        logic [7:0]  tag;
        logic [7:0]  sb;
        logic [7:0]  lo;
        logic [7:0]  fsz;
        logic [23:0] isz;
        logic [15:0] tot;
        logic [7:0]  flen;
        logic [7:0]  opt;
        logic        idm, bvn, avn, sok;
    } t_frame;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_tag = '0, i_second_byte = '0, i_frame_low = '0, i_frame_size = '0;
    logic [23:0] i_image_size = '0;
    logic [15:0] i_total_fragments = '0;
    logic [7:0]  i_fragment_length = '0, i_option_byte = '0;
    logic        i_identity_match = 1'b0, i_boot_version_new = 1'b0;
    logic        i_app_version_new = 1'b0, i_store_ok = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_status;
    logic        o_report, o_write_enable, o_boot_target, o_session_active, o_last;
    logic [23:0] o_write_offset;
    logic [15:0] o_lost_number;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    int fail_count, open_count;
    int requests_sent = 0;
    int sessions_run = 0;
    int cycles = 0;
    bit calm = 1'b0;       // set for the closing stretch: no idling on either side

    // bench copy of the codes, so that frames can be built to match them
    logic [7:0]  start_c = 8'd1, data_c = 8'd2, end_c = 8'd3;
    logic [23:0] limit_c = 24'd65536;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    firmware_fragment_receiver dut (.*);

    ffr_session_checker checker_i (
        .clk(i_clk), .rst_n(i_rst_n),
        .in_valid(i_in_valid), .in_stall(o_in_stall),
        .tag(i_tag), .second_byte(i_second_byte), .frame_low(i_frame_low),
        .frame_size(i_frame_size), .image_size(i_image_size),
        .total_fragments(i_total_fragments), .fragment_length(i_fragment_length),
        .option_byte(i_option_byte), .identity_match(i_identity_match),
        .boot_version_new(i_boot_version_new), .app_version_new(i_app_version_new),
        .store_ok(i_store_ok),
        .out_valid(o_out_valid), .out_stall(i_out_stall),
        .status(o_status), .report(o_report), .write_enable(o_write_enable),
        .write_offset(o_write_offset), .boot_target(o_boot_target),
        .session_active(o_session_active), .lost_number(o_lost_number), .last(o_last),
        .cfg_valid(i_cfg_valid), .cfg_ready(o_cfg_ready),
        .cfg_index(i_cfg_index), .cfg_data(i_cfg_data),
        .fail_count(fail_count), .open_count(open_count)
    );

    // Watchdog: give up well past the slowest correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: alternate bursts of ready and stall; hold stall low once calm.
    initial begin
        forever begin
            if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                if ($urandom_range(0, 1)) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_frame noise();
        t_frame f;
        f.tag  = 8'($urandom);
        f.sb   = 8'($urandom);
        f.lo   = 8'($urandom);
        f.fsz  = 8'($urandom);
        f.isz  = 24'($urandom);
        f.tot  = 16'($urandom);
        f.flen = 8'($urandom);
        f.opt  = 8'($urandom);
        f.idm  = 1'($urandom);
        f.bvn  = 1'($urandom);
        f.avn  = 1'($urandom);
        f.sok  = 1'($urandom);
        return f;
    endfunction

    // Build a start request with identity match, new versions, size below a nonzero limit.
    function automatic t_frame start_req(input logic [15:0] tot, input logic [7:0] flen,
                                         input logic [7:0] fsz, input logic [7:0] opt);
        t_frame f;
        f      = noise();
        f.tag  = start_c;
        f.fsz  = fsz;
        f.tot  = tot;
        f.flen = flen;
        f.opt  = opt;
        f.isz  = (limit_c == 0) ? 24'($urandom) : 24'($urandom_range(0, limit_c - 1));
        f.idm  = 1'b1;
        f.bvn  = 1'b1;
        f.avn  = 1'b1;
        return f;
    endfunction

    function automatic t_frame data_req(input int num, input bit reissue,
                                        input logic [7:0] flen);
        t_frame f;
        f     = noise();
        f.tag = data_c;
        f.sb  = {reissue, 7'(num >> 8)};
        f.lo  = 8'(num);
        f.fsz = flen;
        f.sok = 1'b1;
        return f;
    endfunction

    function automatic t_frame end_req();
        t_frame f;
        f     = noise();
        f.tag = end_c;
        f.sb  = END_MARK;
        f.fsz = 8'($urandom_range(3, 255));
        return f;
    endfunction

    // Offer one request, perhaps after an idle burst, and hold it until taken.
    task automatic send(input t_frame f);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_tag              <= f.tag;
        i_second_byte      <= f.sb;
        i_frame_low        <= f.lo;
        i_frame_size       <= f.fsz;
        i_image_size       <= f.isz;
        i_total_fragments  <= f.tot;
        i_fragment_length  <= f.flen;
        i_option_byte      <= f.opt;
        i_identity_match   <= f.idm;
        i_boot_version_new <= f.bvn;
        i_app_version_new  <= f.avn;
        i_store_ok         <= f.sok;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
    endtask

    // Drop valid and wait until every expected result is back and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_START_CODE:  start_c = val[7:0];
            CFG_DATA_CODE:   data_c  = val[7:0];
            CFG_END_CODE:    end_c   = val[7:0];
            CFG_IMAGE_LIMIT: limit_c = val;
            default: ;
        endcase
    endtask

    task automatic set_codes(input logic [7:0] s, input logic [7:0] d, input logic [7:0] e,
                             input logic [23:0] lim, input logic [6:0] rtr);
        write_reg(CFG_START_CODE, 24'(s));
        write_reg(CFG_DATA_CODE, 24'(d));
        write_reg(CFG_END_CODE, 24'(e));
        write_reg(CFG_IMAGE_LIMIT, lim);
        write_reg(CFG_DEFAULT_RETRIES, 24'(rtr));
    endtask

    task automatic directed_part();
        t_frame f;
        send(data_req(1, 0, 8'd10));                 // data before any start
        send(data_req(1, 0, 8'd10));                 // status no longer idle: ignored
        f = start_req(16'd6, 8'd2, 8'd22, 8'h82);
        f.isz = 24'hFFFFFF;
        send(f);                                     // image too large
        f = start_req(16'd6, 8'd2, 8'd22, 8'h82);
        f.idm = 1'b0;
        send(f);                                     // wrong device
        f = start_req(16'd6, 8'd2, 8'd21, 8'h82);
        f.avn = 1'b0;
        send(f);                                     // no option byte, same version
        send(start_req(16'd6, 8'd2, 8'd20, 8'h82));  // start frame too short
        // open: boot target, two retries, frame length below the header size
        send(start_req(16'd6, 8'd2, 8'd22, 8'h82));
        send(data_req(0, 0, 8'd2));                  // fragment zero
        send(data_req(7, 0, 8'd2));                  // above the total
        send(data_req(1, 0, 8'd3));                  // wrong frame size
        send(data_req(1, 0, 8'd2));
        send(data_req(4, 0, 8'd2));                  // gap: 2 and 3 listed
        send(data_req(5, 1, 8'd2));                  // reissue not in the list
        send(data_req(2, 1, 8'd2));                  // reissue removes 2
        f = data_req(6, 0, 8'd2);
        f.sok = 1'b0;
        send(f);                                     // write failed
        send(end_req());                             // statistics do not add up
        // widest number and offset; the gap overflows the loss list
        send(start_req(16'hFFFF, 8'd255, 8'd255, 8'h01));
        send(data_req(32'h7FFF, 0, 8'd255));
        // overflow during the trailing fill
        send(start_req(16'd100, 8'd21, 8'd21, 8'h00));
        send(data_req(1, 0, 8'd21));
        send(end_req());
        // loss report, one reissue, then the retries run out
        send(start_req(16'd4, 8'd10, 8'd22, 8'h01));
        send(data_req(2, 0, 8'd10));
        send(data_req(4, 0, 8'd10));
        send(end_req());
        send(data_req(1, 1, 8'd10));
        send(end_req());
    endtask

    // One session with random content: mostly in order, with gaps, reissues and faults.
    task automatic random_session();
        t_frame f;
        logic [15:0] tot;
        logic [7:0]  flen;
        int          num, steps, rounds;
        sessions_run++;
        tot  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 45));
        flen = 8'($urandom);
        f = start_req(tot, flen, 8'($urandom_range(21, 255)), 8'($urandom));
        if ($urandom_range(0, 7) == 0) f.bvn = 1'b0;
        if ($urandom_range(0, 7) == 0) f.avn = 1'b0;
        send(f);
        num   = 0;
        steps = $urandom_range(1, 12);
        for (int k = 0; k < steps; k++) begin
            case ($urandom_range(0, 9))
                0, 1: f = data_req($urandom_range(1, num + 1), 1, flen);
                2: begin
                    f = data_req(num + 1, 0, flen);
                    f.sok = 1'b0;
                end
                3: f = data_req(num + 1, 0, 8'($urandom));
                default: begin
                    num = num + (($urandom_range(0, 2) == 0) ? $urandom_range(2, 8) : 1);
                    f = data_req(num, 0, flen);
                end
            endcase
            send(f);
        end
        rounds = $urandom_range(1, 4);
        for (int k = 0; k < rounds; k++) begin
            send(end_req());
            if ($urandom_range(0, 1)) send(data_req($urandom_range(1, num + 2), 1, flen));
        end
    endtask

    task automatic random_part(input int count);
        int goal;
        goal = requests_sent + count;
        while (requests_sent < goal) begin
            if ($urandom_range(0, 5) == 0) send(noise());
            else random_session();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();
        drain();                                     // hold off until all results are in
        random_part(25);
        drain();

        // extreme codes, widest image limit, most retries
        set_codes(8'h00, 8'hFF, 8'h80, 24'hFFFFFF, 7'd127);
        random_part(25);
        drain();

        // all codes equal and a zero limit: every start is oversize
        set_codes(8'h07, 8'h07, 8'h07, 24'd0, 7'd0);
        random_part(10);
        drain();

        // shared codes with a working limit; close without idling
        set_codes(8'h55, 8'h55, 8'h55, 24'd1000, 7'd0);
        random_part(20);
        calm = 1'b1;
        random_part(20);
        drain();

        $display("Covered %0d requests in %0d random sessions over four code settings,",
                 requests_sent, sessions_run);
        $display("including loss reports, list overflow, reissues and shared codes.");
        if (fail_count == 0 && open_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
